// ===== hdl/round_robin_thread_scheduler_unit_assert.svh =====
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_UNIT_ASSERT_SVH

// Checks that a condition implies a consequence at the same clock edge.
`define RRTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Checks that a condition implies a consequence at the following clock edge.
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== hdl/rrts_pkg.sv =====
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int unsigned SLOTS = 16;
    localparam int unsigned ID_W  = $clog2(SLOTS);
    localparam int unsigned CNT_W = ID_W + 1;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [CNT_W-1:0] t_cnt;

    // Transaction modes.
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_YIELD  = 2'd1;
    localparam logic [1:0] MODE_SCHED  = 2'd2;
    localparam logic [1:0] MODE_EXIT   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_DEAD    = 3'd3;
    localparam logic [2:0] ST_ALLEXIT = 3'd4;

    // Result id reported on failure (minus one).
    localparam logic [4:0] RID_NONE = 5'h1F;

    // Run queue commands.
    localparam logic [1:0] QOP_HOLD     = 2'd0;
    localparam logic [1:0] QOP_SHIFT_DN = 2'd1;
    localparam logic [1:0] QOP_SHIFT_UP = 2'd2;
    localparam logic [1:0] QOP_WRITE    = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        t_id        idx;
        t_id        data;
    } t_q_cmd;

endpackage

// ===== hdl/rrts_queue.sv =====
`timescale 1ns / 1ps

module rrts_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rrts_pkg::t_q_cmd        i_cmd,
    output rrts_pkg::t_id           o_head,
    output rrts_pkg::t_id           o_second,
    output rrts_pkg::t_id           o_tail
);

    rrts_pkg::t_id r_q [rrts_pkg::SLOTS];
    rrts_pkg::t_id n_q [rrts_pkg::SLOTS];

    // The queue shifts as a whole: down moves entry i to i+1, up moves i+1 to i; write sets one entry.
    always_comb begin
        for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
            n_q[i] = r_q[i];
        end
        unique case (i_cmd.op)
            rrts_pkg::QOP_SHIFT_DN: begin
                n_q[0] = i_cmd.data;
                for (int i = 1; i < rrts_pkg::SLOTS; i++) begin
                    n_q[i] = r_q[i-1];
                end
            end
            rrts_pkg::QOP_SHIFT_UP: begin
                for (int i = 0; i < rrts_pkg::SLOTS - 1; i++) begin
                    n_q[i] = r_q[i+1];
                end
                n_q[rrts_pkg::SLOTS-1] = i_cmd.data;
            end
            rrts_pkg::QOP_WRITE: begin
                n_q[i_cmd.idx] = i_cmd.data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
                r_q[i] <= '0;
            end
        end else begin
            for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
                r_q[i] <= n_q[i];
            end
        end
    end

    assign o_head   = r_q[0];
    assign o_second = r_q[1];
    assign o_tail   = r_q[rrts_pkg::SLOTS-1];

endmodule

// ===== hdl/round_robin_thread_scheduler_unit.sv =====
// A rejected transaction goes straight to its result. A create examines one slot per cycle from
// the allocation pointer; an exit makes a downward rotation pass over the run queue shift register,
// and a yield or schedule makes a downward pass and then an upward pass.
// One transaction is in flight at a time; the next is accepted once the result is loaded.
// Synchronous active-low reset: slot 0 live and running, queue holding slot 0, pointer at 1.
`timescale 1ns / 1ps
`include "round_robin_thread_scheduler_unit_assert.svh"

module round_robin_thread_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_target,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_result_id,
    output logic [3:0]  o_running,
    output logic [4:0]  o_live_count
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_PASS_DN  = 3'd2;
    localparam logic [2:0] S_PASS_UP  = 3'd3;
    localparam logic [2:0] S_EXIT_END = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    // Phases of a rotation pass.
    localparam logic [1:0] PH_PRE   = 2'd0;
    localparam logic [1:0] PH_SHIFT = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    logic [2:0]                  r_state, n_state;
    logic [rrts_pkg::ID_W-1:0]   r_step, n_step;
    logic [1:0]                  r_phase, n_phase;
    rrts_pkg::t_id               r_carry, n_carry;
    rrts_pkg::t_id               r_key, n_key;
    rrts_pkg::t_id               r_tgt, n_tgt;
    rrts_pkg::t_id               r_prev, n_prev;
    rrts_pkg::t_id               r_ptr, n_ptr;
    logic [1:0]                  r_op, n_op;
    logic [rrts_pkg::SLOTS-1:0]  r_live, n_live;
    rrts_pkg::t_cnt              r_count, n_count;
    rrts_pkg::t_id               r_aptr, n_aptr;
    rrts_pkg::t_id               r_cur, n_cur;
    logic [2:0]                  r_res_status, n_res_status;
    logic [4:0]                  r_res_id, n_res_id;
    logic                        r_ovalid, n_ovalid;
    logic [2:0]                  r_o_status, n_o_status;
    logic [4:0]                  r_o_rid, n_o_rid;
    rrts_pkg::t_id               r_o_running, n_o_running;
    rrts_pkg::t_cnt              r_o_count, n_o_count;

    rrts_pkg::t_q_cmd            q_cmd;
    rrts_pkg::t_id               q_head;
    rrts_pkg::t_id               q_second;
    rrts_pkg::t_id               q_tail;
    rrts_pkg::t_id               yield_tgt;
    logic                        dn_in_live;

    // The run queue is a shift register that rotates one place per cycle during a pass. A
    // pass over all SLOTS places brings every entry back to its place, with one entry taken out
    // and one put in on the way.
    rrts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (q_cmd),
        .o_head   (q_head),
        .o_second (q_second),
        .o_tail   (q_tail)
    );

    // A schedule yields to the second queue entry, or to the head when it is alone.
    assign yield_tgt = (i_mode == rrts_pkg::MODE_SCHED)
                     ? ((r_count == rrts_pkg::t_cnt'(1)) ? q_head : q_second)
                     : i_target[rrts_pkg::ID_W-1:0];

    // During the downward pass the tail shows entry SLOTS-1-step; it lies in the
    // live part of the queue when that position is below the count.
    assign dn_in_live = ({1'b0, ~r_step} < r_count);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_phase      = r_phase;
        n_carry      = r_carry;
        n_key        = r_key;
        n_tgt        = r_tgt;
        n_prev       = r_prev;
        n_ptr        = r_ptr;
        n_op         = r_op;
        n_live       = r_live;
        n_count      = r_count;
        n_aptr       = r_aptr;
        n_cur        = r_cur;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_ovalid     = r_ovalid;
        n_o_status   = r_o_status;
        n_o_rid      = r_o_rid;
        n_o_running  = r_o_running;
        n_o_count    = r_o_count;
        q_cmd.op     = rrts_pkg::QOP_HOLD;
        q_cmd.idx    = r_count[rrts_pkg::ID_W-1:0];
        q_cmd.data   = r_ptr;

        // The downstream side takes the waiting result.
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op         = i_mode;
                    n_prev       = r_cur;
                    n_res_status = rrts_pkg::ST_OK;
                    n_res_id     = rrts_pkg::RID_NONE;
                    n_step       = '0;
                    n_phase      = PH_PRE;
                    n_tgt        = yield_tgt;
                    n_key        = q_head;
                    unique case (i_mode)
                        rrts_pkg::MODE_CREATE: begin
                            if (r_count[rrts_pkg::ID_W]) begin
                                n_res_status = rrts_pkg::ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_ptr   = r_aptr;
                                n_state = S_SCAN;
                            end
                        end
                        rrts_pkg::MODE_YIELD: begin
                            if (i_target[7:rrts_pkg::ID_W] != '0) begin
                                n_res_status = rrts_pkg::ST_RANGE;
                                n_state      = S_DONE;
                            end else if (!r_live[i_target[rrts_pkg::ID_W-1:0]]) begin
                                n_res_status = rrts_pkg::ST_DEAD;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_PASS_DN;
                            end
                        end
                        rrts_pkg::MODE_SCHED: begin
                            if (r_count == '0) begin
                                n_res_status = rrts_pkg::ST_ALLEXIT;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_PASS_DN;
                            end
                        end
                        rrts_pkg::MODE_EXIT: begin
                            if (r_count == '0) begin
                                n_res_status = rrts_pkg::ST_ALLEXIT;
                                n_state      = S_DONE;
                            end else if (!r_live[r_cur]) begin
                                n_res_status = rrts_pkg::ST_DEAD;
                                n_state      = S_DONE;
                            end else begin
                                // The downward pass removes the running thread.
                                n_live[r_cur] = 1'b0;
                                n_key         = r_cur;
                                n_state       = S_PASS_DN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (!r_live[r_ptr]) begin
                    n_live[r_ptr] = 1'b1;
                    n_aptr        = r_ptr + rrts_pkg::t_id'(1);
                    q_cmd.op      = rrts_pkg::QOP_WRITE;
                    n_count       = r_count + rrts_pkg::t_cnt'(1);
                    n_res_id      = {1'b0, r_ptr};
                    n_state       = S_DONE;
                end else begin
                    n_ptr  = r_ptr + rrts_pkg::t_id'(1);
                    n_step = r_step + 1'b1;
                    if (r_step == '1) begin
                        n_res_status = rrts_pkg::ST_FULL;
                        n_state      = S_DONE;
                    end
                end
            end

            S_PASS_DN: begin
                // Deletes the first live entry equal to the key, walking down from the
                // top, and puts the key at the last live position. With the head as key
                // this moves the head to the tail; with the running id it removes it.
                q_cmd.op   = rrts_pkg::QOP_SHIFT_DN;
                q_cmd.data = q_tail;
                case (r_phase)
                    PH_PRE: begin
                        if (dn_in_live) begin
                            q_cmd.data = r_key;
                            if (q_tail == r_key) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_carry = q_tail;
                                n_phase = PH_SHIFT;
                            end
                        end
                    end
                    PH_SHIFT: begin
                        q_cmd.data = r_carry;
                        if (q_tail == r_key) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_carry = q_tail;
                        end
                    end
                    default: begin
                    end
                endcase
                n_step = r_step + 1'b1;
                if (r_step == '1) begin
                    if (r_op == rrts_pkg::MODE_EXIT) begin
                        n_count = r_count - rrts_pkg::t_cnt'(1);
                        n_state = S_EXIT_END;
                    end else begin
                        n_phase = PH_SHIFT;
                        n_carry = r_tgt;
                        n_state = S_PASS_UP;
                    end
                end
            end

            S_PASS_UP: begin
                // Moves the target to the head: entries above it shift one place down
                // the queue until the target itself comes past.
                q_cmd.op   = rrts_pkg::QOP_SHIFT_UP;
                q_cmd.data = q_head;
                if (r_phase == PH_SHIFT) begin
                    q_cmd.data = r_carry;
                    if (q_head == r_tgt) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_carry = q_head;
                    end
                end
                n_step = r_step + 1'b1;
                if (r_step == '1) begin
                    n_cur    = r_tgt;
                    n_res_id = {1'b0, r_prev};
                    n_state  = S_DONE;
                end
            end

            S_EXIT_END: begin
                // Yielding to the new head leaves the queue as it is.
                if (r_count == '0) begin
                    n_res_status = rrts_pkg::ST_ALLEXIT;
                end else begin
                    n_cur    = q_head;
                    n_res_id = {1'b0, r_prev};
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid    = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_rid     = r_res_id;
                    n_o_running = r_cur;
                    n_o_count   = r_count;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_phase  <= PH_PRE;
            r_op     <= rrts_pkg::MODE_CREATE;
            r_live   <= rrts_pkg::SLOTS'(1);
            r_count  <= rrts_pkg::t_cnt'(1);
            r_aptr   <= rrts_pkg::t_id'(1);
            r_cur    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_live   <= n_live;
            r_count  <= n_count;
            r_aptr   <= n_aptr;
            r_cur    <= n_cur;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry      <= n_carry;
        r_key        <= n_key;
        r_tgt        <= n_tgt;
        r_prev       <= n_prev;
        r_ptr        <= n_ptr;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_o_status   <= n_o_status;
        r_o_rid      <= n_o_rid;
        r_o_running  <= n_o_running;
        r_o_count    <= n_o_count;
    end

    // Input transactions are taken only while the sequencer is idle.
    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_status     = r_o_status;
    assign o_result_id  = r_o_rid;
    assign o_running    = r_o_running;
    assign o_live_count = r_o_count;

    // Between transactions the live count matches the number of live slots.
    `RRTS_ASSERT_NOW(a_count_matches_live, r_state == S_IDLE, $countones(r_live) == r_count)
    // Any failure status goes out with the minus-one id.
    `RRTS_ASSERT_NOW(a_fail_id, o_valid && o_status != rrts_pkg::ST_OK, o_result_id == rrts_pkg::RID_NONE)
    // An accepted transaction always leaves the idle state.
    `RRTS_ASSERT_NEXT(a_accept_busy, i_valid && !o_stall, r_state != S_IDLE)

endmodule
